FILE: hdl/running_mean_stddev_min_max_assert.svh
// ----------------------------------------------------------------------------
// Running statistics assertion macros
// Shorthand for clocked assertions on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_STDDEV_MIN_MAX_ASSERT_SVH
`define RUNNING_MEAN_STDDEV_MIN_MAX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMSMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMSMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rmsmm_pkg.sv
// ----------------------------------------------------------------------------
// Running statistics package
// Fixed widths, item op codes, datapath commands and width helpers.
// ----------------------------------------------------------------------------
package rmsmm_pkg;

    localparam int SUM_W = 40;
    localparam int SQ_W  = 56;
    localparam int STD_W = 16;
    localparam int OP_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_MERGE = 2'd1,
        OP_FINAL = 2'd2,
        OP_CLEAR = 2'd3
    } item_op_t;

    typedef enum logic [3:0] {
        DP_NOP         = 4'd0,
        DP_LOAD        = 4'd1,
        DP_CLEAR       = 4'd2,
        DP_COMMIT      = 4'd3,
        DP_DIV_STEP    = 4'd4,
        DP_MEAN_SAVE   = 4'd5,
        DP_MUL_STEP    = 4'd6,
        DP_MULB_LOAD   = 4'd7,
        DP_SUB         = 4'd8,
        DP_DIV_RESTART = 4'd9,
        DP_SQRT_LOAD   = 4'd10,
        DP_SQRT_STEP   = 4'd11,
        DP_EMIT        = 4'd12
    } dp_op_t;

    // Work register width: holds n*sumsq and sum^2, rounded up to even for
    // the two-bits-per-step square root.
    function automatic int acc_width(input int cb);
        int w;
        w = (cb + SQ_W > 2 * SUM_W) ? cb + SQ_W : 2 * SUM_W;
        return ((w + 1) / 2) * 2;
    endfunction

    // Multiplier operand width: the count or the sum magnitude.
    function automatic int mul_width(input int cb);
        return (cb > SUM_W) ? cb : SUM_W;
    endfunction

endpackage

FILE: hdl/rmsmm_dp.sv
// ----------------------------------------------------------------------------
// Running statistics datapath
// Accumulator state, item operand registers, shift-add multiplier,
// restoring divider, digit-by-digit square root and result register.
// ----------------------------------------------------------------------------
module rmsmm_dp import rmsmm_pkg::*; #(
    parameter int COUNT_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dp_op_t                        dp_op,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [COUNT_BITS-1:0]  part_count,
    input  logic signed [SUM_W-1:0]       part_sum,
    input  logic        [SQ_W-1:0]        part_sumsq,
    input  logic signed [SAMPLE_BITS-1:0] part_min,
    input  logic signed [SAMPLE_BITS-1:0] part_max,
    input  logic                          item_is_add,
    output logic                          count_zero,
    output logic signed [SAMPLE_BITS-1:0] mean,
    output logic        [STD_W-1:0]       std_dev,
    output logic signed [SAMPLE_BITS-1:0] minimum,
    output logic signed [SAMPLE_BITS-1:0] maximum,
    output logic        [COUNT_BITS-1:0]  sample_count,
    output logic                          empty_res,
    output logic                          overflowed
);

    localparam int CB    = COUNT_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam int ACC_W = acc_width(COUNT_BITS);
    localparam int MUL_W = mul_width(COUNT_BITS);

    localparam logic [ACC_W-1:0] MEAN_POS_MAX = ACC_W'(2 ** (SB - 1) - 1);
    localparam logic [ACC_W-1:0] MEAN_NEG_MAG = ACC_W'(2 ** (SB - 1));
    localparam logic [ACC_W-1:0] STD_MAX      = ACC_W'(2 ** STD_W - 1);

    // accumulator state
    logic        [CB-1:0]    count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic        [SQ_W-1:0]  sumsq_reg, sumsq_next;
    logic signed [SB-1:0]    min_reg, min_next, max_reg, max_next;
    logic                    ovf_reg, ovf_next;

    // operands of the pending add or merge
    logic        [CB-1:0]    oc_reg, oc_next;
    logic signed [SUM_W-1:0] os_reg, os_next;
    logic        [SQ_W-1:0]  oq_reg, oq_next;
    logic signed [SB-1:0]    omin_reg, omin_next, omax_reg, omax_next;

    // finalize work registers
    logic [ACC_W-1:0] wa_reg, wa_next, wb_reg, wb_next, wc_reg, wc_next;
    logic [MUL_W-1:0] wm_reg, wm_next;
    logic [CB-1:0]    rem_reg, rem_next;
    logic signed [SB-1:0] mean_reg, mean_next;

    // result register
    logic signed [SB-1:0]    res_mean_reg, res_mean_next;
    logic        [STD_W-1:0] res_std_reg, res_std_next;
    logic signed [SB-1:0]    res_min_reg, res_min_next, res_max_reg, res_max_next;
    logic        [CB-1:0]    res_cnt_reg, res_cnt_next;
    logic                    res_empty_reg, res_empty_next, res_ovf_reg, res_ovf_next;

    logic        [SUM_W-1:0] sum_mag;
    logic signed [2*SB-1:0]  sq_prod;
    logic        [CB:0]      nc;
    logic signed [SUM_W:0]   ns;
    logic        [SQ_W:0]    nq;
    logic                    fits;
    logic        [CB+1:0]    div_trial;
    logic                    div_ok;
    logic signed [SB-1:0]    mean_sat;
    logic        [ACC_W-1:0] sq_rem, sq_try;
    logic        [ACC_W:0]   sq_diff;

    assign count_zero = (count_reg == '0);

    always_comb begin
        sum_mag = sum_reg[SUM_W-1] ? ($unsigned(~sum_reg) + SUM_W'(1)) : $unsigned(sum_reg);
        sq_prod = sample * sample;

        nc   = {1'b0, count_reg} + {1'b0, oc_reg};
        ns   = {sum_reg[SUM_W-1], sum_reg} + {os_reg[SUM_W-1], os_reg};
        nq   = {1'b0, sumsq_reg} + {1'b0, oq_reg};
        fits = !nc[CB] && (ns[SUM_W] == ns[SUM_W-1]) && !nq[SQ_W];

        div_trial = {1'b0, rem_reg, wa_reg[ACC_W-1]} - {2'b00, count_reg};
        div_ok    = !div_trial[CB+1];

        // truncated quotient magnitude in wa, clamp to the sample range
        if (!sum_reg[SUM_W-1]) begin
            mean_sat = (wa_reg > MEAN_POS_MAX) ? {1'b0, {(SB-1){1'b1}}} : wa_reg[SB-1:0];
        end else begin
            mean_sat = (wa_reg > MEAN_NEG_MAG) ? {1'b1, {(SB-1){1'b0}}}
                                               : SB'(-wa_reg[SB-1:0]);
        end

        sq_rem  = {wc_reg[ACC_W-3:0], wa_reg[ACC_W-1:ACC_W-2]};
        sq_try  = {wb_reg[ACC_W-3:0], 2'b01};
        sq_diff = {1'b0, sq_rem} - {1'b0, sq_try};
    end

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        oc_next    = oc_reg;
        os_next    = os_reg;
        oq_next    = oq_reg;
        omin_next  = omin_reg;
        omax_next  = omax_reg;
        wa_next    = wa_reg;
        wb_next    = wb_reg;
        wc_next    = wc_reg;
        wm_next    = wm_reg;
        rem_next   = rem_reg;
        mean_next  = mean_reg;
        res_mean_next  = res_mean_reg;
        res_std_next   = res_std_reg;
        res_min_next   = res_min_reg;
        res_max_next   = res_max_reg;
        res_cnt_next   = res_cnt_reg;
        res_empty_next = res_empty_reg;
        res_ovf_next   = res_ovf_reg;

        unique case (dp_op)
            DP_NOP: begin
            end
            DP_LOAD: begin
                if (item_is_add) begin
                    oc_next   = CB'(1);
                    os_next   = SUM_W'(sample);
                    oq_next   = SQ_W'($unsigned(sq_prod));
                    omin_next = sample;
                    omax_next = sample;
                end else begin
                    oc_next   = part_count;
                    os_next   = part_sum;
                    oq_next   = part_sumsq;
                    omin_next = part_min;
                    omax_next = part_max;
                end
                // prime the mean division in case this is a finalize
                wa_next  = ACC_W'(sum_mag);
                rem_next = '0;
            end
            DP_CLEAR: begin
                count_next = '0;
                sum_next   = '0;
                sumsq_next = '0;
                min_next   = '0;
                max_next   = '0;
                ovf_next   = 1'b0;
            end
            DP_COMMIT: begin
                if (oc_reg != '0) begin
                    if (!fits) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = nc[CB-1:0];
                        sum_next   = ns[SUM_W-1:0];
                        sumsq_next = nq[SQ_W-1:0];
                        if (count_reg == '0) begin
                            min_next = omin_reg;
                            max_next = omax_reg;
                        end else begin
                            if (omin_reg < min_reg) min_next = omin_reg;
                            if (omax_reg > max_reg) max_next = omax_reg;
                        end
                    end
                end
            end
            DP_DIV_STEP: begin
                wa_next = {wa_reg[ACC_W-2:0], div_ok};
                if (div_ok) begin
                    rem_next = div_trial[CB-1:0];
                end else begin
                    rem_next = {rem_reg[CB-2:0], wa_reg[ACC_W-1]};
                end
            end
            DP_MEAN_SAVE: begin
                mean_next = mean_sat;
                wa_next   = '0;
                wb_next   = ACC_W'(sumsq_reg);
                wm_next   = MUL_W'(count_reg);
            end
            DP_MUL_STEP: begin
                if (wm_reg[0]) wa_next = wa_reg + wb_reg;
                wb_next = {wb_reg[ACC_W-2:0], 1'b0};
                wm_next = {1'b0, wm_reg[MUL_W-1:1]};
            end
            DP_MULB_LOAD: begin
                wc_next = wa_reg;
                wa_next = '0;
                wb_next = ACC_W'(sum_mag);
                wm_next = MUL_W'(sum_mag);
            end
            DP_SUB: begin
                // inconsistent sums give zero variance
                wa_next  = (wc_reg >= wa_reg) ? (wc_reg - wa_reg) : '0;
                rem_next = '0;
            end
            DP_DIV_RESTART: begin
                rem_next = '0;
            end
            DP_SQRT_LOAD: begin
                wb_next = '0;
                wc_next = '0;
            end
            DP_SQRT_STEP: begin
                wa_next = {wa_reg[ACC_W-3:0], 2'b00};
                if (!sq_diff[ACC_W]) begin
                    wc_next = sq_diff[ACC_W-1:0];
                    wb_next = {wb_reg[ACC_W-2:0], 1'b1};
                end else begin
                    wc_next = sq_rem;
                    wb_next = {wb_reg[ACC_W-2:0], 1'b0};
                end
            end
            DP_EMIT: begin
                res_ovf_next = ovf_reg;
                if (count_reg == '0) begin
                    res_mean_next  = '0;
                    res_std_next   = '0;
                    res_min_next   = '0;
                    res_max_next   = '0;
                    res_cnt_next   = '0;
                    res_empty_next = 1'b1;
                end else begin
                    res_mean_next  = mean_reg;
                    res_std_next   = (wb_reg > STD_MAX) ? '1 : wb_reg[STD_W-1:0];
                    res_min_next   = min_reg;
                    res_max_next   = max_reg;
                    res_cnt_next   = count_reg;
                    res_empty_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        oc_reg        <= oc_next;
        os_reg        <= os_next;
        oq_reg        <= oq_next;
        omin_reg      <= omin_next;
        omax_reg      <= omax_next;
        wa_reg        <= wa_next;
        wb_reg        <= wb_next;
        wc_reg        <= wc_next;
        wm_reg        <= wm_next;
        rem_reg       <= rem_next;
        mean_reg      <= mean_next;
        res_mean_reg  <= res_mean_next;
        res_std_reg   <= res_std_next;
        res_min_reg   <= res_min_next;
        res_max_reg   <= res_max_next;
        res_cnt_reg   <= res_cnt_next;
        res_empty_reg <= res_empty_next;
        res_ovf_reg   <= res_ovf_next;
    end

    assign mean         = res_mean_reg;
    assign std_dev      = res_std_reg;
    assign minimum      = res_min_reg;
    assign maximum      = res_max_reg;
    assign sample_count = res_cnt_reg;
    assign empty_res    = res_empty_reg;
    assign overflowed   = res_ovf_reg;

endmodule

FILE: hdl/rmsmm_ctrl.sv
// ----------------------------------------------------------------------------
// Running statistics controller
// Sequences item intake, commit and the finalize phases; owns the step
// counter and the result valid flag.
// ----------------------------------------------------------------------------
`include "running_mean_stddev_min_max_assert.svh"

module rmsmm_ctrl import rmsmm_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  item_op_t in_op,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  logic     count_zero,
    output dp_op_t   dp_op
);

    localparam int ACC_W = acc_width(COUNT_BITS);
    localparam int MUL_W = mul_width(COUNT_BITS);
    localparam int CNT_W = $clog2(ACC_W);

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ACC_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ACC_W / 2 - 1);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'h0001,
        ST_COMMIT   = 14'h0002,
        ST_MEAN     = 14'h0004,
        ST_MEAN_SV  = 14'h0008,
        ST_MUL_A    = 14'h0010,
        ST_MULB_LD  = 14'h0020,
        ST_MUL_B    = 14'h0040,
        ST_SUB      = 14'h0080,
        ST_DIV_A    = 14'h0100,
        ST_DIV_RST  = 14'h0200,
        ST_DIV_B    = 14'h0400,
        ST_SQ_LD    = 14'h0800,
        ST_SQRT     = 14'h1000,
        ST_EMIT     = 14'h2000
    } ctrl_state_t;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;
    logic             cnt_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cnt_done  = (cnt_reg == '0);
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg - 1'b1;
        dp_op          = DP_NOP;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op) inside
                        OP_ADD, OP_MERGE: begin
                            dp_op      = DP_LOAD;
                            state_next = ST_COMMIT;
                        end
                        OP_CLEAR: begin
                            dp_op = DP_CLEAR;
                        end
                        OP_FINAL: begin
                            dp_op      = DP_LOAD;
                            state_next = count_zero ? ST_EMIT : ST_MEAN;
                            cnt_next   = DIV_LAST;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COMMIT: begin
                dp_op      = DP_COMMIT;
                state_next = ST_IDLE;
            end
            ST_MEAN: begin
                dp_op = DP_DIV_STEP;
                if (cnt_done) state_next = ST_MEAN_SV;
            end
            ST_MEAN_SV: begin
                dp_op      = DP_MEAN_SAVE;
                state_next = ST_MUL_A;
                cnt_next   = MUL_LAST;
            end
            ST_MUL_A: begin
                dp_op = DP_MUL_STEP;
                if (cnt_done) state_next = ST_MULB_LD;
            end
            ST_MULB_LD: begin
                dp_op      = DP_MULB_LOAD;
                state_next = ST_MUL_B;
                cnt_next   = MUL_LAST;
            end
            ST_MUL_B: begin
                dp_op = DP_MUL_STEP;
                if (cnt_done) state_next = ST_SUB;
            end
            ST_SUB: begin
                dp_op      = DP_SUB;
                state_next = ST_DIV_A;
                cnt_next   = DIV_LAST;
            end
            ST_DIV_A: begin
                dp_op = DP_DIV_STEP;
                if (cnt_done) state_next = ST_DIV_RST;
            end
            ST_DIV_RST: begin
                dp_op      = DP_DIV_RESTART;
                state_next = ST_DIV_B;
                cnt_next   = DIV_LAST;
            end
            ST_DIV_B: begin
                dp_op = DP_DIV_STEP;
                if (cnt_done) state_next = ST_SQ_LD;
            end
            ST_SQ_LD: begin
                dp_op      = DP_SQRT_LOAD;
                state_next = ST_SQRT;
                cnt_next   = SQRT_LAST;
            end
            ST_SQRT: begin
                dp_op = DP_SQRT_STEP;
                if (cnt_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the result register is free
                if (out_free) begin
                    dp_op          = DP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RMSMM_ASSERT_NEXT(a_add_commits, accept && (in_op == OP_ADD || in_op == OP_MERGE), state_reg == ST_COMMIT, "accepted add or merge not committed")
    `RMSMM_ASSERT_NEXT(a_emit_valid, state_reg == ST_EMIT && out_free, out_valid_reg, "finalize result not presented")
    `RMSMM_ASSERT_SAME(a_no_overwrite, out_valid_reg && !out_ready, dp_op != DP_EMIT, "pending result overwritten")
    `RMSMM_ASSERT_NEXT(a_sqrt_ends, state_reg == ST_SQRT && cnt_done, state_reg == ST_EMIT, "square root overran")

endmodule

FILE: hdl/running_mean_stddev_min_max.sv
// Add, merge: accepted in idle, committed next cycle, no item taken meanwhile.
// Clear: applied at the accepting edge. Empty finalize: the emit state waits
// for a free result register. Finalize: mean division, two products,
// subtraction, two divisions and the square root, by the one-bit-per-cycle
// units, then emit. aresetn (synchronous, active low) zeroes count, sums, min,
// max, overflow flag, result valid; idles the controller; no clearing pass.
// ----------------------------------------------------------------------------
// Running mean, standard deviation, minimum and maximum accumulator
// Stream in add, merge, finalize and clear items; finalize streams out one
// statistics result and leaves the accumulator untouched.
// ----------------------------------------------------------------------------
module running_mean_stddev_min_max import rmsmm_pkg::*; #(
    parameter int COUNT_BITS  = 24,
    parameter int SAMPLE_BITS = 16,
    localparam int S_TDATA_W = ((3 * SAMPLE_BITS + COUNT_BITS + SUM_W + SQ_W + 7) / 8) * 8,
    localparam int M_TDATA_W = ((3 * SAMPLE_BITS + STD_W + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // sample, part_count, part_sum, part_sumsq, part_min, part_max
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic [OP_W-1:0]      s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // mean, std_dev, minimum, maximum, sample_count
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // empty_res, overflowed
    output logic [1:0]           m_axis_tuser
);

    // input field offsets in tdata, lowest first
    localparam int OFS_PCNT = SAMPLE_BITS;
    localparam int OFS_PSUM = OFS_PCNT + COUNT_BITS;
    localparam int OFS_PSQ  = OFS_PSUM + SUM_W;
    localparam int OFS_PMIN = OFS_PSQ + SQ_W;
    localparam int OFS_PMAX = OFS_PMIN + SAMPLE_BITS;

    dp_op_t                        dp_op;
    logic                          count_zero;
    item_op_t                      in_op;
    logic signed [SAMPLE_BITS-1:0] mean, minimum, maximum;
    logic        [STD_W-1:0]       std_dev;
    logic        [COUNT_BITS-1:0]  sample_count;
    logic                          empty_res, overflowed;

    assign in_op = item_op_t'(s_axis_tuser);

    // Controller: takes a transfer only in idle, runs the finalize phases,
    // and holds the result valid until the sink takes it.
    rmsmm_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_op      (in_op),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .count_zero (count_zero),
        .dp_op      (dp_op)
    );

    // Datapath: payload is captured straight off the bus on the accepting
    // edge, so tdata need only be stable while tvalid and tready are high.
    rmsmm_dp #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .dp_op        (dp_op),
        .sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .part_count   (s_axis_tdata[OFS_PCNT +: COUNT_BITS]),
        .part_sum     (s_axis_tdata[OFS_PSUM +: SUM_W]),
        .part_sumsq   (s_axis_tdata[OFS_PSQ +: SQ_W]),
        .part_min     (s_axis_tdata[OFS_PMIN +: SAMPLE_BITS]),
        .part_max     (s_axis_tdata[OFS_PMAX +: SAMPLE_BITS]),
        .item_is_add  (in_op == OP_ADD),
        .count_zero   (count_zero),
        .mean         (mean),
        .std_dev      (std_dev),
        .minimum      (minimum),
        .maximum      (maximum),
        .sample_count (sample_count),
        .empty_res    (empty_res),
        .overflowed   (overflowed)
    );

    // Pack the result register, padding tdata with zeros to whole bytes.
    assign m_axis_tdata = M_TDATA_W'({sample_count, maximum, minimum, std_dev, mean});
    assign m_axis_tuser = {overflowed, empty_res};

endmodule

FILE: bench/running_mean_stddev_min_max_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics accumulator testbench
// Streams add, merge, finalize and clear items into the accumulator and checks
// each finalize result field by field against a cycle-free model of the
// count, sums, min, max and sticky overflow flag. A short scripted pass hits
// the corner cases; a long random pass follows, with random gaps and stalls
// on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module running_mean_stddev_min_max_tb;
    import rmsmm_pkg::*;

    localparam int S_W = ((3 * 16 + 24 + SUM_W + SQ_W + 7) / 8) * 8;
    localparam int M_W = ((3 * 16 + STD_W + 24 + 7) / 8) * 8;

    localparam longint CNT_TOP    = 64'h0000_0000_00FF_FFFF;
    localparam longint SUM_TOP    = 64'h0000_007F_FFFF_FFFF;
    localparam longint SUM_BOTTOM = -SUM_TOP - 1;
    localparam longint SQ_TOP     = 64'h00FF_FFFF_FFFF_FFFF;

    localparam int N_RANDOM         = 1625;
    localparam int QUIET_ITEMS      = 150;
    localparam int LONG_HOLD_CYCLES = 2500;
    localparam int DRAIN_CYCLES     = 400;

    typedef struct {
        item_op_t                op;
        logic signed [15:0]      sample;
        logic        [23:0]      part_count;
        logic signed [39:0]      part_sum;
        logic        [55:0]      part_sumsq;
        logic signed [15:0]      part_min;
        logic signed [15:0]      part_max;
    } stat_item_t;

    typedef struct packed {
        logic [15:0] mean;
        logic [15:0] std_dev;
        logic [15:0] minimum;
        logic [15:0] maximum;
        logic [23:0] sample_count;
        logic        empty_res;
        logic        overflowed;
    } stats_res_t;

    // A scripted row; fixed marks a finalize whose result is typed in.
    typedef struct {
        stat_item_t item;
        bit         fixed;
        stats_res_t res;
    } script_row_t;

    logic           aclk;
    logic           aresetn;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    // sample, part_count, part_sum, part_sumsq, part_min, part_max
    logic [S_W-1:0] s_axis_tdata;
    // op
    logic [OP_W-1:0] s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    // mean, std_dev, minimum, maximum, sample_count
    logic [M_W-1:0] m_axis_tdata;
    // empty_res, overflowed
    logic [1:0]     m_axis_tuser;

    // Accumulator mirror
    longint acc_count, acc_sum, acc_sumsq, acc_min, acc_max;
    bit     acc_ovf;

    stats_res_t pending_stats[$];
    int         mismatches;
    bit         quiet_tail;
    bit         hold_output;

    running_mean_stddev_min_max dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic bit sums_fit(input longint n, input longint s, input longint q);
        return n <= CNT_TOP && s >= SUM_BOTTOM && s <= SUM_TOP && q <= SQ_TOP;
    endfunction

    // Apply one item to the mirror; return 1 and the statistics on finalize.
    function automatic bit stats_step(input stat_item_t it, output stats_res_t r);
        longint      x, pc, ps, pq, pmin, pmax, nc, ns, nq, mag, mean_q;
        logic [127:0] scaled_sq, sq_of_sum, spread;
        logic [63:0] var_q, root, trial;
        int          i;
        r = '0;
        case (it.op)
            OP_ADD: begin
                x  = it.sample;
                nc = acc_count + 1;
                ns = acc_sum + x;
                nq = acc_sumsq + x * x;
                if (!sums_fit(nc, ns, nq)) begin
                    acc_ovf = 1'b1;
                end else begin
                    if (acc_count == 0) begin
                        acc_min = x;
                        acc_max = x;
                    end else begin
                        if (x < acc_min) acc_min = x;
                        if (x > acc_max) acc_max = x;
                    end
                    acc_count = nc;
                    acc_sum   = ns;
                    acc_sumsq = nq;
                end
                return 1'b0;
            end
            OP_MERGE: begin
                pc   = it.part_count;
                ps   = it.part_sum;
                pq   = it.part_sumsq;
                pmin = it.part_min;
                pmax = it.part_max;
                nc   = acc_count + pc;
                ns   = acc_sum + ps;
                nq   = acc_sumsq + pq;
                // An empty partial changes nothing, not even the flag.
                if (pc != 0) begin
                    if (!sums_fit(nc, ns, nq)) begin
                        acc_ovf = 1'b1;
                    end else begin
                        if (acc_count == 0) begin
                            acc_min = pmin;
                            acc_max = pmax;
                        end else begin
                            if (pmin < acc_min) acc_min = pmin;
                            if (pmax > acc_max) acc_max = pmax;
                        end
                        acc_count = nc;
                        acc_sum   = ns;
                        acc_sumsq = nq;
                    end
                end
                return 1'b0;
            end
            OP_CLEAR: begin
                acc_count = 0;
                acc_sum   = 0;
                acc_sumsq = 0;
                acc_min   = 0;
                acc_max   = 0;
                acc_ovf   = 1'b0;
                return 1'b0;
            end
            default: begin
                r.overflowed = acc_ovf;
                if (acc_count == 0) begin
                    r.empty_res = 1'b1;
                    return 1'b1;
                end
                mean_q = acc_sum / acc_count;
                if (mean_q > 32767) mean_q = 32767;
                if (mean_q < -32768) mean_q = -32768;
                mag       = (acc_sum < 0) ? -acc_sum : acc_sum;
                scaled_sq = 128'(acc_count) * 128'(acc_sumsq);
                sq_of_sum = 128'(mag) * 128'(mag);
                var_q     = '0;
                // Inconsistent sums give a negative spread: take zero.
                if (scaled_sq >= sq_of_sum) begin
                    spread = (scaled_sq - sq_of_sum) / 128'(acc_count) / 128'(acc_count);
                    var_q  = spread[63:0];
                end
                root = '0;
                for (i = 31; i >= 0; i--) begin
                    trial = root | (64'd1 << i);
                    if (trial * trial <= var_q) root = trial;
                end
                r.mean         = 16'(mean_q);
                r.std_dev      = (root > 64'd65535) ? 16'hFFFF : root[15:0];
                r.minimum      = 16'(acc_min);
                r.maximum      = 16'(acc_max);
                r.sample_count = 24'(acc_count);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic script_row_t stim_row(input item_op_t op, input logic [15:0] smp,
                                             input logic [23:0] pc, input logic [39:0] ps,
                                             input logic [55:0] pq, input logic [15:0] pmin,
                                             input logic [15:0] pmax);
        script_row_t row;
        row.item.op         = op;
        row.item.sample     = smp;
        row.item.part_count = pc;
        row.item.part_sum   = ps;
        row.item.part_sumsq = pq;
        row.item.part_min   = pmin;
        row.item.part_max   = pmax;
        row.fixed           = 1'b0;
        row.res             = '0;
        return row;
    endfunction

    function automatic script_row_t finalize_row(input bit fixed, input logic [15:0] mean,
                                                 input logic [15:0] sd, input logic [15:0] mn,
                                                 input logic [15:0] mx, input logic [23:0] cnt,
                                                 input bit empty, input bit ovf);
        script_row_t row;
        row       = stim_row(OP_FINAL, '0, '0, '0, '0, '0, '0);
        row.fixed = fixed;
        row.res   = '{mean, sd, mn, mx, cnt, empty, ovf};
        return row;
    endfunction

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($urandom_range(0, 1023)) - 16'sd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic stat_item_t random_item();
        stat_item_t         it;
        int                 pick, k, rep, j;
        longint             s, q, v, lo, hi;
        pick = $urandom_range(0, 99);
        it.op         = (pick < 68) ? OP_ADD : (pick < 84) ? OP_MERGE :
                        (pick < 94) ? OP_FINAL : OP_CLEAR;
        it.sample     = random_sample();
        it.part_count = 24'($urandom);
        it.part_sum   = 40'({$urandom, $urandom});
        it.part_sumsq = 56'({$urandom, $urandom});
        it.part_min   = 16'($urandom);
        it.part_max   = 16'($urandom);
        if (it.op == OP_MERGE) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                it.part_count = '0;
            end else if (pick < 80) begin
                // Well-formed partial: a few real samples, optionally repeated.
                k  = $urandom_range(1, 6);
                s  = 0;
                q  = 0;
                lo = 0;
                hi = 0;
                for (j = 0; j < k; j++) begin
                    v = random_sample();
                    s += v;
                    q += v * v;
                    if (j == 0 || v < lo) lo = v;
                    if (j == 0 || v > hi) hi = v;
                end
                rep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40000) : 1;
                it.part_count = 24'(k * rep);
                it.part_sum   = 40'(s * rep);
                it.part_sumsq = 56'(q * rep);
                it.part_min   = 16'(lo);
                it.part_max   = 16'(hi);
            end
        end
        return it;
    endfunction

    // Offer one item, after an idle gap when gap is nonzero; update the mirror at the transfer.
    task automatic drive_item(input script_row_t row, input int gap);
        stats_res_t predicted;
        bit         produced;
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.item.part_max, row.item.part_min, row.item.part_sumsq,
                          row.item.part_sum, row.item.part_count, row.item.sample};
        s_axis_tuser  <= row.item.op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        produced = stats_step(row.item, predicted);
        if (produced) pending_stats.push_back(row.fixed ? row.res : predicted);
    endtask

    task automatic cmp_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Stimulus: reset, scripted corner cases, random stream, drain.
    initial begin : stimulus
        script_row_t script[$];
        script_row_t row;
        int          i, gap, idle_pct;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        mismatches    = 0;
        quiet_tail    = 1'b0;
        hold_output   = 1'b0;
        acc_count     = 0;
        acc_sum       = 0;
        acc_sumsq     = 0;
        acc_min       = 0;
        acc_max       = 0;
        acc_ovf       = 1'b0;
        idle_pct      = 20;

        // Finalize straight after reset: empty result.
        script.push_back(finalize_row(1, 0, 0, 0, 0, 0, 1, 0));
        // Both sample extremes; mean of -1/2 truncates to zero.
        script.push_back(stim_row(OP_ADD, 16'h7FFF, 0, 0, 0, 0, 0));
        script.push_back(stim_row(OP_ADD, 16'h8000, 0, 0, 0, 0, 0));
        script.push_back(finalize_row(0, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(stim_row(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        // Empty partial is ignored.
        script.push_back(stim_row(OP_MERGE, 16'h1234, 0, 40'h12_3456_789A, 56'd1234,
                                  16'd5, 16'd6));
        script.push_back(finalize_row(1, 0, 0, 0, 0, 0, 1, 0));
        // Merge into empty copies the partial; then an add and an
        // inconsistent partial whose sums give a negative spread.
        script.push_back(stim_row(OP_MERGE, 0, 24'd3, 40'd300, 56'd50000,
                                  -16'sd50, 16'sd250));
        script.push_back(stim_row(OP_ADD, 16'h0200, 0, 0, 0, 0, 0));
        script.push_back(stim_row(OP_MERGE, 0, 24'd2, 40'd100000, 56'd0,
                                  -16'sd7, 16'sd900));
        script.push_back(finalize_row(0, 0, 0, 0, 0, 0, 0, 0));
        // Largest sum: mean saturates high; one more unit overflows the sum.
        script.push_back(stim_row(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        script.push_back(stim_row(OP_MERGE, 0, 24'd1, 40'h7F_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF,
                                  16'h8000, 16'h7FFF));
        script.push_back(stim_row(OP_MERGE, 0, 24'd1, 40'd1, 56'd0, 0, 0));
        script.push_back(finalize_row(1, 16'h7FFF, 0, 16'h8000, 16'h7FFF, 1, 0, 1));
        // Largest sum of squares: std_dev saturates; a further add overflows it.
        script.push_back(stim_row(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        script.push_back(stim_row(OP_MERGE, 0, 24'd1, 40'd0, 56'hFF_FFFF_FFFF_FFFF, 0, 0));
        script.push_back(stim_row(OP_ADD, 16'h0001, 0, 0, 0, 0, 0));
        script.push_back(finalize_row(1, 0, 16'hFFFF, 0, 0, 1, 0, 1));
        // Full count with the lowest sum: mean saturates low, count saturates.
        script.push_back(stim_row(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        script.push_back(stim_row(OP_MERGE, 0, 24'hFF_FFFF, 40'h80_0000_0000, 56'd0,
                                  -16'sd5, 16'sd5));
        script.push_back(stim_row(OP_ADD, 16'h0007, 0, 0, 0, 0, 0));
        script.push_back(finalize_row(1, 16'h8000, 0, 16'hFFFB, 16'h0005, 24'hFF_FFFF, 0, 1));
        // Clear drops the sticky flag.
        script.push_back(stim_row(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        script.push_back(finalize_row(1, 0, 0, 0, 0, 0, 1, 0));

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[k]) begin
            gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 18) : 0;
            drive_item(script[k], gap);
        end

        for (i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 50;
                endcase
            end
            // Stall the output for a long stretch while items keep coming.
            if (i == 200) hold_output = 1'b1;
            quiet_tail = (i >= N_RANDOM - QUIET_ITEMS);
            gap = (!quiet_tail && $urandom_range(0, 99) < idle_pct) ?
                  $urandom_range(1, 18) : 0;
            row.item  = random_item();
            row.fixed = 1'b0;
            row.res   = '0;
            drive_item(row, gap);
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("running_mean_stddev_min_max verification clean");
        end else begin
            $display("running_mean_stddev_min_max verification failed");
        end
        $finish;
    end

    // Output ready: random stall bursts, one long hold-off, none at the tail.
    initial begin : result_ready
        int stall_len, stall_pct;
        m_axis_tready = 1'b0;
        stall_pct     = 20;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 299) == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 45;
                endcase
            end
            if (hold_output) begin
                hold_output = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                m_axis_tready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                stall_len = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(negedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Check every output transfer against the oldest pending result.
    always @(posedge aclk) begin : result_check
        stats_res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_stats.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_stats.pop_front();
                cmp_field("mean", $signed(want.mean), $signed(m_axis_tdata[15:0]));
                cmp_field("std_dev", want.std_dev, m_axis_tdata[31:16]);
                cmp_field("minimum", $signed(want.minimum), $signed(m_axis_tdata[47:32]));
                cmp_field("maximum", $signed(want.maximum), $signed(m_axis_tdata[63:48]));
                cmp_field("sample_count", want.sample_count, m_axis_tdata[87:64]);
                cmp_field("empty_res", want.empty_res, m_axis_tuser[0]);
                cmp_field("overflowed", want.overflowed, m_axis_tuser[1]);
            end
        end
    end

    // Watchdog: several times the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("running_mean_stddev_min_max verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rmsmm_pkg.sv
hdl/rmsmm_dp.sv
hdl/rmsmm_ctrl.sv
hdl/running_mean_stddev_min_max.sv
bench/running_mean_stddev_min_max_tb.sv
